// File: src/btrp_pkg.sv
// Shared types and constants of the box table ray pick unit.
package btrp_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DIV_STEPS = 49;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [30:0] BOX_RESET = 31'd196608;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_PICK = 1'b1;
    localparam logic [2:0] ADDR_BOX_SIZE = 3'd0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOHIT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CSCAN,
        S_PREAD,
        S_AXIS,
        S_DIV,
        S_ISECT,
        S_RES
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    slot_clr;
        logic    slot_inc;
        logic    mem_wr;
        logic    mem_rd;
        logic    t_init;
        logic    axis_inc;
        logic    div_start;
        logic    div_sel;
        logic    div_step;
        logic    store_a;
        logic    store_b;
        logic    t_update;
        logic    res_load;
        t_status res_code;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_pick;
        logic slot_free;
        logic slot_last;
        logic dir_zero;
        logic in_slab;
        logic div_done;
        logic bnd;
        logic axis_last;
        logic miss;
        logic out_full;
    } t_dp_stat;

endpackage

// File: src/btrp_if.sv
// Request and response channel interfaces of the box table ray pick unit.
interface btrp_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source(output valid, cmd, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   input ready);
    modport sink(input valid, cmd, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface btrp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] slot;

    modport source(output valid, status, slot, input ready);
    modport sink(input valid, status, slot, output ready);
endinterface

// File: src/btrp_datapath.sv
// Datapath: slot table, corner memory, serial divider and slab interval logic.
module btrp_datapath import btrp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_stat           o_stat,
    input  logic [30:0]        i_box_size,
    input  logic               i_in_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_out_status,
    output logic [5:0]         o_out_slot
);

    logic                  r_cmd;
    logic signed [31:0]    r_pos [3];
    logic signed [31:0]    r_dir [3];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [95:0]           r_mem [SLOT_COUNT];
    logic [95:0]           r_rd;
    logic [SLOT_W-1:0]     r_idx;
    logic [1:0]            r_axis;
    logic                  r_bnd;
    logic [31:0]           r_rem;
    logic [DIV_STEPS-1:0]  r_q;
    logic [CNT_W-1:0]      r_cnt;
    logic [31:0]           r_dvs;
    logic                  r_neg;
    logic signed [31:0]    r_ta;
    logic signed [31:0]    r_tb;
    logic signed [31:0]    r_tmin;
    logic signed [31:0]    r_tmax;
    logic                  r_out_valid;
    t_status               r_status;
    logic [5:0]            r_slot;

    logic signed [31:0] c_corner;
    logic signed [31:0] c_o;
    logic signed [31:0] c_d;
    logic signed [32:0] c_bmin;
    logic signed [32:0] c_bmax;
    logic signed [33:0] c_diff;
    logic [33:0]        c_mag;
    logic [31:0]        c_dmag;
    logic [32:0]        c_sh;
    logic [32:0]        c_trial;
    logic               c_ge;
    logic signed [31:0] c_t;
    logic signed [31:0] c_lo;
    logic signed [31:0] c_hi;

    always_comb begin
        unique case (r_axis)
            2'd0:    c_corner = r_rd[31:0];
            2'd1:    c_corner = r_rd[63:32];
            default: c_corner = r_rd[95:64];
        endcase
        c_o = r_pos[r_axis];
        c_d = r_dir[r_axis];
        c_bmin = 33'(c_corner);
        c_bmax = c_bmin + $signed({2'b00, i_box_size});
        c_diff = i_cmd.div_sel ? (34'(c_bmax) - 34'(c_o)) : (34'(c_bmin) - 34'(c_o));
        c_mag = c_diff[33] ? 34'(-c_diff) : c_diff;
        c_dmag = c_d[31] ? (~c_d + 32'd1) : c_d;
        // One restoring step of the unsigned magnitude division.
        c_sh = {r_rem, r_q[DIV_STEPS-1]};
        c_trial = c_sh - {1'b0, r_dvs};
        c_ge = !c_trial[32];
        // Quotient truncates toward zero and saturates to the 32-bit range.
        if (r_neg) begin
            c_t = (r_q >= DIV_STEPS'(33'h0_8000_0000)) ? T_MIN : -$signed(r_q[31:0]);
        end else begin
            c_t = (r_q > DIV_STEPS'(33'h0_7FFF_FFFF)) ? T_MAX : $signed(r_q[31:0]);
        end
        c_lo = (r_ta > r_tb) ? r_tb : r_ta;
        c_hi = (r_ta > r_tb) ? r_ta : r_tb;
    end

    assign o_stat.is_pick   = (r_cmd == CMD_PICK);
    assign o_stat.slot_free = !r_valid[r_idx];
    assign o_stat.slot_last = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign o_stat.dir_zero  = (c_d == 32'sd0);
    assign o_stat.in_slab   = (33'(c_o) >= c_bmin) && (33'(c_o) <= c_bmax);
    assign o_stat.div_done  = (r_cnt == CNT_W'(DIV_STEPS));
    assign o_stat.bnd       = r_bnd;
    assign o_stat.axis_last = (r_axis == 2'd2);
    assign o_stat.miss      = (r_tmin > c_hi) || (c_lo > r_tmax);
    assign o_stat.out_full  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_idx] <= {r_pos[2], r_pos[1], r_pos[0]};
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mem_wr) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_cmd;
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end
        if (i_cmd.slot_clr) begin
            r_idx <= '0;
        end else if (i_cmd.slot_inc) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        if (i_cmd.t_init) begin
            r_axis <= 2'd0;
            r_tmin <= T_MIN;
            r_tmax <= T_MAX;
        end else begin
            if (i_cmd.axis_inc) begin
                r_axis <= r_axis + 2'd1;
            end
            if (i_cmd.t_update) begin
                if (c_lo > r_tmin) begin
                    r_tmin <= c_lo;
                end
                if (c_hi < r_tmax) begin
                    r_tmax <= c_hi;
                end
            end
        end
        if (i_cmd.store_a) begin
            r_ta <= c_t;
        end
        if (i_cmd.store_b) begin
            r_tb <= c_t;
        end
        if (i_cmd.div_start) begin
            r_bnd <= i_cmd.div_sel;
            r_q <= {c_mag[32:0], 16'h0000};
            r_rem <= '0;
            r_cnt <= '0;
            r_dvs <= c_dmag;
            r_neg <= c_diff[33] ^ c_d[31];
        end else if (i_cmd.div_step) begin
            r_q <= {r_q[DIV_STEPS-2:0], c_ge};
            r_rem <= c_ge ? c_trial[31:0] : c_sh[31:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_code;
            r_slot <= (i_cmd.res_code == ST_OK) ? 6'(r_idx) : 6'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_status = r_status;
    assign o_out_slot = r_slot;

endmodule

// File: src/btrp_ctrl.sv
// Controller state machine that sequences create scans and pick slab tests.
module btrp_ctrl import btrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code = r_code;
        o_cmd = '0;
        o_cmd.res_code = r_code;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.slot_clr = 1'b1;
                    n_state = S_CSCAN;
                end
            end
            S_CSCAN: begin
                if (i_stat.is_pick) begin
                    n_state = S_PREAD;
                end else if (i_stat.slot_free) begin
                    o_cmd.mem_wr = 1'b1;
                    n_code = ST_OK;
                    n_state = S_RES;
                end else if (i_stat.slot_last) begin
                    n_code = ST_FULL;
                    n_state = S_RES;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_PREAD: begin
                if (!i_stat.slot_free) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.t_init = 1'b1;
                    n_state = S_AXIS;
                end else if (i_stat.slot_last) begin
                    n_code = ST_NOHIT;
                    n_state = S_RES;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_AXIS: begin
                if (!i_stat.dir_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (!i_stat.in_slab) begin
                    if (i_stat.slot_last) begin
                        n_code = ST_NOHIT;
                        n_state = S_RES;
                    end else begin
                        o_cmd.slot_inc = 1'b1;
                        n_state = S_PREAD;
                    end
                end else if (i_stat.axis_last) begin
                    n_code = ST_OK;
                    n_state = S_RES;
                end else begin
                    // A zero direction inside the slab leaves the interval unchanged.
                    o_cmd.axis_inc = 1'b1;
                end
            end
            S_DIV: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (!i_stat.bnd) begin
                    o_cmd.store_a = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = 1'b1;
                end else begin
                    o_cmd.store_b = 1'b1;
                    n_state = S_ISECT;
                end
            end
            S_ISECT: begin
                if (i_stat.miss) begin
                    if (i_stat.slot_last) begin
                        n_code = ST_NOHIT;
                        n_state = S_RES;
                    end else begin
                        o_cmd.slot_inc = 1'b1;
                        n_state = S_PREAD;
                    end
                end else begin
                    o_cmd.t_update = 1'b1;
                    if (i_stat.axis_last) begin
                        n_code = ST_OK;
                        n_state = S_RES;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                        n_state = S_AXIS;
                    end
                end
            end
            S_RES: begin
                if (!i_stat.out_full) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/box_table_ray_pick_unit.sv
// Top level of the box table ray pick unit.
// The unit keeps a table of SLOT_COUNT axis-aligned cubes and answers two
// requests on the i_req channel: create stores a corner in the lowest free
// slot, and pick returns the lowest slot whose cube the ray line meets.
// Every request gives exactly one transfer on the o_rsp channel, with a
// status code and a slot number.
// Requests are handled one at a time; the free search of a create steps one
// slot a cycle. A pick passes over empty slots one a cycle and, for each
// valid slot, tests the axes in turn: a zero-direction axis only checks the
// origin against the slab, while a nonzero one needs both slab quotients,
// on which the shared bit-serial divider spends 49 steps each.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; it then waits only to hand over its own.
// The cube edge register sits at APB address 0; the user must write it only
// while idle, as the block itself does not enforce this.
// Reset empties the table and sets the edge to 3.0; corners are not cleared.
module box_table_ray_pick_unit import btrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btrp_req_if.sink    i_req,
    btrp_rsp_if.source  o_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [30:0] r_box_size;
    t_ctrl_cmd   w_cmd;
    t_dp_stat    w_stat;
    logic        w_in_ready;
    logic        w_cfg_wr;

    assign w_cfg_wr = i_psel && i_penable && i_pwrite
                      && ({i_paddr[2], 2'b00} == ADDR_BOX_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_size <= BOX_RESET;
        end else if (w_cfg_wr) begin
            r_box_size <= i_pwdata[30:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = ({i_paddr[2], 2'b00} == ADDR_BOX_SIZE) ? {1'b0, r_box_size} : 32'd0;
    assign i_req.ready = w_in_ready;

    btrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    btrp_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_box_size   (r_box_size),
        .i_in_cmd     (i_req.cmd),
        .i_pos_x      (i_req.pos_x),
        .i_pos_y      (i_req.pos_y),
        .i_pos_z      (i_req.pos_z),
        .i_dir_x      (i_req.dir_x),
        .i_dir_y      (i_req.dir_y),
        .i_dir_z      (i_req.dir_z),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_out_status (o_rsp.status),
        .o_out_slot   (o_rsp.slot)
    );

endmodule

// File: sim/box_table_ray_pick_unit_tb.sv
// Self-checking testbench of the box table ray pick unit: random creates and picks against a cube table predictor.
`timescale 1ns / 1ps

module box_table_ray_pick_unit_tb;
    import btrp_pkg::*;

    typedef struct {
        t_status    status;
        logic [5:0] slot;
    } t_pick_result;

    class box_pick_scoreboard;
        logic [30:0]  edge_len;
        bit           occupied[SLOT_COUNT];
        int           corner[SLOT_COUNT][3];
        t_pick_result expected[$];
        int           errors;

        function new();
            edge_len = BOX_RESET;
            errors = 0;
            foreach (occupied[k]) occupied[k] = 0;
        endfunction

        function int used();
            int n;
            n = 0;
            foreach (occupied[k]) n += occupied[k];
            return n;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function longint clip_t(longint v);
            if (v > longint'(T_MAX)) return longint'(T_MAX);
            if (v < longint'(T_MIN)) return longint'(T_MIN);
            return v;
        endfunction

        // Slab interval of one axis; returns 0 when the axis rejects the ray outright.
        function bit axis_span(int c, int o, int d, output longint lo, output longint hi);
            longint bmin, bmax, ol, a, b, s;
            bmin = c;
            bmax = bmin + longint'(edge_len);
            ol = o;
            if (d == 0) begin
                if (ol < bmin || ol > bmax) return 0;
                lo = longint'(T_MIN);
                hi = longint'(T_MAX);
                return 1;
            end
            a = clip_t(((bmin - ol) * 65536) / longint'(d));
            b = clip_t(((bmax - ol) * 65536) / longint'(d));
            if (a > b) begin
                s = a;
                a = b;
                b = s;
            end
            lo = a;
            hi = b;
            return 1;
        endfunction

        function bit ray_meets(int k, int o[3], int d[3]);
            longint tmin, tmax, lo, hi;
            tmin = longint'(T_MIN);
            tmax = longint'(T_MAX);
            for (int ax = 0; ax < 3; ax++) begin
                if (!axis_span(corner[k][ax], o[ax], d[ax], lo, hi)) return 0;
                if (tmin > hi || lo > tmax) return 0;
                if (lo > tmin) tmin = lo;
                if (hi < tmax) tmax = hi;
            end
            return 1;
        endfunction

        function void note_request(logic c, int px, int py, int pz, int dx, int dy, int dz);
            t_pick_result r;
            int o[3];
            int d[3];
            o = '{px, py, pz};
            d = '{dx, dy, dz};
            r.slot = '0;
            if (c == CMD_CREATE) begin
                r.status = ST_FULL;
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (!occupied[k]) begin
                        occupied[k] = 1;
                        corner[k] = o;
                        r.status = ST_OK;
                        r.slot = 6'(k);
                        break;
                    end
                end
            end else begin
                r.status = ST_NOHIT;
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (occupied[k] && ray_meets(k, o, d)) begin
                        r.status = ST_OK;
                        r.slot = 6'(k);
                        break;
                    end
                end
            end
            expected.push_back(r);
        endfunction

        function void check_response(logic [1:0] status, logic [5:0] slot);
            t_pick_result r;
            if (expected.size() == 0) begin
                $error("unexpected response: status %0d slot %0d", status, slot);
                errors++;
                return;
            end
            r = expected.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, status);
                errors++;
            end
            if (slot !== r.slot) begin
                $error("slot: expected %0d, got %0d", r.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    btrp_req_if req_ch();
    btrp_rsp_if rsp_ch();

    box_pick_scoreboard sb = new();
    bit no_gaps = 0;
    bit hold_request = 0;

    box_table_ray_pick_unit dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("box_table_ray_pick_unit regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int small_val();
        return int'($urandom_range(0, 64 << 16)) - (32 << 16);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int gap;
        int hold;
        gap = 0;
        hold = 0;
        rsp_ch.ready = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 0;
                hold = 3000;
            end
            if (hold > 0) begin
                rsp_ch.ready = 0;
                hold--;
            end else if (gap > 0) begin
                rsp_ch.ready = 0;
                gap--;
            end else begin
                rsp_ch.ready = 1;
                gap = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.slot);
    end

    task automatic send(input logic c, input int px, input int py, input int pz,
                        input int dx, input int dy, input int dz);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0) begin
            @(negedge clk);
            req_ch.valid = 0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid = 1;
        req_ch.cmd = c;
        req_ch.pos_x = px;
        req_ch.pos_y = py;
        req_ch.pos_z = pz;
        req_ch.dir_x = dx;
        req_ch.dir_y = dy;
        req_ch.dir_z = dz;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(c, px, py, pz, dx, dy, dz);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_box_size(input logic [31:0] value);
        drain();
        repeat (4) @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = ADDR_BOX_SIZE;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        sb.edge_len = value[30:0];
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic random_create(input bit wide);
        if (wide)
            send(CMD_CREATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send(CMD_CREATE, small_val(), small_val(), small_val(),
                 $urandom, $urandom, $urandom);
    endtask

    // A pick whose origin lies inside a chosen cube, so the ray line must meet it.
    task automatic aimed_pick();
        int s;
        int o[3];
        int d[3];
        longint v;
        s = $urandom_range(0, sb.used() - 1);
        for (int ax = 0; ax < 3; ax++) begin
            v = longint'(sb.corner[s][ax]) + longint'($urandom_range(0, sb.edge_len));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            o[ax] = int'(v);
            case ($urandom_range(0, 9))
                0, 1: d[ax] = 0;
                2, 3: d[ax] = $urandom;
                default: d[ax] = small_val();
            endcase
        end
        send(CMD_PICK, o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    task automatic random_phase(input int count, input int cap);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (sb.used() == 0 || (r < 12 && sb.used() < cap))
                random_create($urandom_range(0, 4) == 0);
            else if (r < 22)
                send(CMD_PICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                aimed_pick();
        end
    endtask

    initial begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 0;
        req_ch.cmd = CMD_CREATE;
        req_ch.pos_x = 0;
        req_ch.pos_y = 0;
        req_ch.pos_z = 0;
        req_ch.dir_x = 0;
        req_ch.dir_y = 0;
        req_ch.dir_z = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: empty table, extreme corners, zero directions, saturation.
        send(CMD_PICK, 0, 0, 0, 1 << 16, 0, 0);
        send(CMD_CREATE, 0, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, -1, -1);
        send(CMD_CREATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send(CMD_PICK, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0);
        send(CMD_PICK, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0);
        send(CMD_PICK, -5 << 16, 1 << 16, 1 << 16, 0, 0, 0);
        send(CMD_PICK, 10 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0);
        send(CMD_PICK, 32'h7FFF_FFF0, 1 << 16, 1 << 16, 1, 0, 0);
        send(CMD_PICK, 1 << 16, 1 << 16, 1 << 16, 1, 1, 1);
        send(CMD_PICK, 1 << 16, 2 << 16, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(CMD_PICK, 3 << 16, 0, 3 << 16, 0, 1 << 16, 0);
        send(CMD_PICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send(CMD_PICK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send(CMD_PICK, -(4 << 16), -(4 << 16), -(4 << 16), 1 << 16, 1 << 16, 1 << 16);
        send(CMD_PICK, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1 << 16, -(1 << 16));
        send(CMD_PICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send(CMD_CREATE, 4 << 16, 0, 0, 0, 0, 0);
        send(CMD_PICK, 5 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0);

        set_box_size(32'h0000_0000);
        send(CMD_PICK, 0, 0, 0, 0, 0, 0);
        hold_request = 1;
        random_phase(260, 8);

        set_box_size(32'hFFFF_FFFF);
        no_gaps = 1;
        random_phase(260, 9);
        no_gaps = 0;

        set_box_size($urandom);
        random_phase(260, 10);

        set_box_size(32'h7FFF_FFFF);
        random_phase(200, 10);

        set_box_size(BOX_RESET);
        random_phase(200, 10);

        // Fill the table, then overflow it and pick across all slots.
        set_box_size($urandom_range(1 << 16, 8 << 16));
        while (sb.used() < SLOT_COUNT) random_create($urandom_range(0, 3) == 0);
        repeat (3) random_create(1);
        repeat (4) aimed_pick();
        repeat (5) send(CMD_PICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("box_table_ray_pick_unit regression: pass");
        else
            $display("box_table_ray_pick_unit regression: fail");
        $finish;
    end

endmodule
